@@ src/dcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Drive current protection package
// Shared widths, register indexes and reset values of the protection block.
// ----------------------------------------------------------------------------
package dcp_pkg;

  // Widths of the fixed-format fields
  localparam int unsigned REG_W   = 32;  // rated and peak threshold registers
  localparam int unsigned HEAT_W  = 52;  // heat accumulator and heat level
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values
  localparam logic [REG_W-1:0] RATED_RST    = 32'd65536;
  localparam logic [REG_W-1:0] PEAK_THR_RST = 32'h8000_0000;
  localparam int unsigned      PEAK_DUR_RST = 1000;
  localparam int unsigned      OVER_DUR_RST = 1000;
  localparam int unsigned      COOL_RST     = 30000;

  localparam logic [HEAT_W-1:0] HEAT_MAX = {HEAT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATED    = 3'd0,
    CFG_PEAK_THR = 3'd1,
    CFG_PEAK_DUR = 3'd2,
    CFG_OVER_DUR = 3'd3,
    CFG_COOL     = 3'd4
  } cfg_idx_e;

  // Handshake status between the queue and its neighbours
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ src/dcp_front.sv @@
// ----------------------------------------------------------------------------
// Drive current protection front end
// Squares the d and q currents of each accepted tick and forms the magnitude.
// ----------------------------------------------------------------------------
module dcp_front #(
  parameter int unsigned CURRENT_WIDTH = 16
) (
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [CURRENT_WIDTH-1:0]     d_current_i,
  input  logic [CURRENT_WIDTH-1:0]     q_current_i,
  input  dcp_pkg::queue_status_t       q_status_i,
  output logic                         push_o,
  output logic [2*CURRENT_WIDTH-1:0]   mag_o
);

  localparam int unsigned MAG_W = 2 * CURRENT_WIDTH;

  logic signed [MAG_W-1:0] d_sq;
  logic signed [MAG_W-1:0] q_sq;

  // Each square is non-negative and below 2^(MAG_W-2)+1, so the sum fits MAG_W
  assign d_sq = MAG_W'($signed(d_current_i)) * MAG_W'($signed(d_current_i));
  assign q_sq = MAG_W'($signed(q_current_i)) * MAG_W'($signed(q_current_i));
  assign mag_o = MAG_W'($unsigned(d_sq)) + MAG_W'($unsigned(q_sq));

  assign s_ready_o = !q_status_i.full;
  assign push_o    = s_valid_i && !q_status_i.full;

endmodule

@@ src/dcp_queue.sv @@
// ----------------------------------------------------------------------------
// Drive current protection queue
// Two-entry FIFO of magnitudes between the front end and the back end.
// ----------------------------------------------------------------------------
module dcp_queue #(
  parameter int unsigned DATA_W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [DATA_W-1:0]       push_data_i,
  input  logic                    pop_i,
  output logic [DATA_W-1:0]       pop_data_o,
  output dcp_pkg::queue_status_t  status_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/dcp_back.sv @@
// ----------------------------------------------------------------------------
// Drive current protection back end
// Runs the peak timer, cooling hold and heat accumulator, one tick per cycle
// while its output register can take it, and holds the result there.
// ----------------------------------------------------------------------------
module dcp_back #(
  parameter int unsigned CURRENT_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH   = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dcp_pkg::queue_status_t                q_status_i,
  input  logic [2*CURRENT_WIDTH-1:0]            mag_i,
  output logic                                  pop_o,
  input  logic [dcp_pkg::REG_W-1:0]             rated_i,
  input  logic [dcp_pkg::REG_W-1:0]             peak_thr_i,
  input  logic [TIMER_WIDTH-1:0]                peak_dur_i,
  input  logic [TIMER_WIDTH-1:0]                cool_ticks_i,
  input  logic [dcp_pkg::REG_W+TIMER_WIDTH-1:0] limit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  peak_fault_o,
  output logic                                  overload_fault_o,
  output logic [dcp_pkg::HEAT_W-1:0]            heat_level_o,
  output logic [2*CURRENT_WIDTH-1:0]            mag_o
);

  localparam int unsigned MAG_W  = 2 * CURRENT_WIDTH;
  localparam int unsigned HEAT_W = dcp_pkg::HEAT_W;
  localparam int unsigned LIM_W  = dcp_pkg::REG_W + TIMER_WIDTH;
  localparam int unsigned CMP_W  = (MAG_W > dcp_pkg::REG_W) ? MAG_W : dcp_pkg::REG_W;
  localparam int unsigned LC_W   = (LIM_W > HEAT_W) ? LIM_W : HEAT_W;

  logic [TIMER_WIDTH-1:0] peak_time_q, peak_time_d;
  logic [TIMER_WIDTH-1:0] cool_left_q, cool_left_d;
  logic [HEAT_W-1:0]      heat_q, heat_d;
  logic                   out_valid_q;
  logic                   peak_fault_q, peak_fault_d;
  logic                   over_fault_q, over_fault_d;
  logic [HEAT_W-1:0]      level_q, level_d;
  logic [MAG_W-1:0]       mag_q;

  logic [TIMER_WIDTH-1:0] peak_inc;
  logic [HEAT_W:0]        heat_sum;
  logic [HEAT_W:0]        heat_diff;

  assign pop_o = !q_status_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    peak_time_d  = peak_time_q;
    cool_left_d  = cool_left_q;
    peak_fault_d = 1'b0;
    peak_inc     = peak_time_q + TIMER_WIDTH'(1);

    // Peak timer: run while above threshold, trigger loads the cooling hold
    if (CMP_W'(mag_i) > CMP_W'(peak_thr_i)) begin
      if (peak_inc >= peak_dur_i) begin
        peak_time_d  = peak_dur_i;
        cool_left_d  = cool_ticks_i;
        peak_fault_d = 1'b1;
      end else begin
        peak_time_d = peak_inc;
      end
    end else begin
      peak_time_d = '0;
    end
    if (!peak_fault_d && (cool_left_q != '0)) begin
      cool_left_d  = cool_left_q - TIMER_WIDTH'(1);
      peak_fault_d = 1'b1;
    end

    // Heat: add the magnitude, drop the rated square, floor at zero, saturate
    heat_sum  = (HEAT_W+1)'(heat_q) + (HEAT_W+1)'(mag_i);
    heat_diff = heat_sum - (HEAT_W+1)'(rated_i);
    if (heat_sum < (HEAT_W+1)'(rated_i)) begin
      level_d = '0;
    end else if (heat_diff[HEAT_W]) begin
      level_d = dcp_pkg::HEAT_MAX;
    end else begin
      level_d = heat_diff[HEAT_W-1:0];
    end

    // Clamp at the overload limit
    if (LC_W'(level_d) >= LC_W'(limit_i)) begin
      heat_d       = HEAT_W'(limit_i);
      over_fault_d = 1'b1;
    end else begin
      heat_d       = level_d;
      over_fault_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_time_q <= '0;
      cool_left_q <= '0;
      heat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        peak_time_q <= peak_time_d;
        cool_left_q <= cool_left_d;
        heat_q      <= heat_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      peak_fault_q <= peak_fault_d;
      over_fault_q <= over_fault_d;
      level_q      <= level_d;
      mag_q        <= mag_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign peak_fault_o     = peak_fault_q;
  assign overload_fault_o = over_fault_q;
  assign heat_level_o     = level_q;
  assign mag_o            = mag_q;

endmodule

@@ src/drive_current_protection_unit.sv @@
// ----------------------------------------------------------------------------
// Drive current protection unit
// Peak current timer with cooling hold and I2t overload heat accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one monitoring tick per transfer: the d and q
//   currents in signed fixed point. The master stream returns one result per
//   tick: peak fault, overload fault, heat level and the squared magnitude.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; the user must do so only while the block is idle, and the
//   block itself does not enforce it. Writes to unknown indexes are dropped.
// Timing:
//   A tick accepted on the slave side is written into the queue, popped when
//   the back end's output register is free or being read, and held there for
//   the master side. One tick is accepted every cycle while the queue is not
//   full; the back end updates its timer and heat state as it pops a tick.
//   The overload limit is a registered product of two registers and follows
//   a register write through the configuration and limit registers.
// Reset:
//   Registers return to their defaults, timers and heat clear, and the
//   two-entry queue and output register empty.
// Stalls:
//   When the receiver holds tready low the result stays on the port and the
//   queue absorbs up to two further ticks before s_axis_tready falls.
// ----------------------------------------------------------------------------
module drive_current_protection_unit #(
  parameter int unsigned CURRENT_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH   = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Slave stream; tdata from bit 0: d_current, q_current, zero fill
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((2*CURRENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Master stream; tdata from bit 0: peak_fault, overload_fault, heat_level,
  // magnitude_squared, zero fill
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((2+dcp_pkg::HEAT_W+2*CURRENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [dcp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dcp_pkg::REG_W-1:0]            cfg_data_i
);

  localparam int unsigned MAG_W   = 2 * CURRENT_WIDTH;
  localparam int unsigned OUT_FW  = 2 + dcp_pkg::HEAT_W + MAG_W;
  localparam int unsigned OUT_DW  = ((OUT_FW + 7) / 8) * 8;
  localparam int unsigned LIM_W   = dcp_pkg::REG_W + TIMER_WIDTH;

  localparam logic [TIMER_WIDTH-1:0] PEAK_DUR_RST_T = TIMER_WIDTH'(dcp_pkg::PEAK_DUR_RST);
  localparam logic [TIMER_WIDTH-1:0] OVER_DUR_RST_T = TIMER_WIDTH'(dcp_pkg::OVER_DUR_RST);
  localparam logic [TIMER_WIDTH-1:0] COOL_RST_T     = TIMER_WIDTH'(dcp_pkg::COOL_RST);
  localparam logic [LIM_W-1:0]       LIMIT_RST      =
    LIM_W'(dcp_pkg::RATED_RST) * LIM_W'(OVER_DUR_RST_T);

  // Configuration registers
  logic [dcp_pkg::REG_W-1:0] rated_q;
  logic [dcp_pkg::REG_W-1:0] peak_thr_q;
  logic [TIMER_WIDTH-1:0]    peak_dur_q;
  logic [TIMER_WIDTH-1:0]    over_dur_q;
  logic [TIMER_WIDTH-1:0]    cool_ticks_q;
  logic [LIM_W-1:0]          limit_q, limit_d;

  dcp_pkg::queue_status_t    q_status;
  logic                      push;
  logic                      pop;
  logic [MAG_W-1:0]          front_mag;
  logic [MAG_W-1:0]          queue_mag;

  logic                      peak_fault;
  logic                      over_fault;
  logic [dcp_pkg::HEAT_W-1:0] heat_level;
  logic [MAG_W-1:0]          out_mag;

  // Take register writes; unknown indexes fall through to the default arm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rated_q      <= dcp_pkg::RATED_RST;
      peak_thr_q   <= dcp_pkg::PEAK_THR_RST;
      peak_dur_q   <= PEAK_DUR_RST_T;
      over_dur_q   <= OVER_DUR_RST_T;
      cool_ticks_q <= COOL_RST_T;
    end else if (cfg_we_i) begin
      case (dcp_pkg::cfg_idx_e'(cfg_idx_i))
        dcp_pkg::CFG_RATED:    rated_q      <= cfg_data_i;
        dcp_pkg::CFG_PEAK_THR: peak_thr_q   <= cfg_data_i;
        dcp_pkg::CFG_PEAK_DUR: peak_dur_q   <= cfg_data_i[TIMER_WIDTH-1:0];
        dcp_pkg::CFG_OVER_DUR: over_dur_q   <= cfg_data_i[TIMER_WIDTH-1:0];
        dcp_pkg::CFG_COOL:     cool_ticks_q <= cfg_data_i[TIMER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Overload limit: rated square times overload duration, held in a register
  assign limit_d = LIM_W'(rated_q) * LIM_W'(over_dur_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else begin
      limit_q <= limit_d;
    end
  end

  // Front end: square the currents and push the magnitude
  dcp_front #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
  ) u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .d_current_i (s_axis_tdata[CURRENT_WIDTH-1:0]),
    .q_current_i (s_axis_tdata[MAG_W-1:CURRENT_WIDTH]),
    .q_status_i  (q_status),
    .push_o      (push),
    .mag_o       (front_mag)
  );

  // Queue between front and back, so either side may stall on its own
  dcp_queue #(
    .DATA_W (MAG_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_mag),
    .pop_i       (pop),
    .pop_data_o  (queue_mag),
    .status_o    (q_status)
  );

  // Back end: timers, heat and the output register
  dcp_back #(
    .CURRENT_WIDTH (CURRENT_WIDTH),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_status_i       (q_status),
    .mag_i            (queue_mag),
    .pop_o            (pop),
    .rated_i          (rated_q),
    .peak_thr_i       (peak_thr_q),
    .peak_dur_i       (peak_dur_q),
    .cool_ticks_i     (cool_ticks_q),
    .limit_i          (limit_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .peak_fault_o     (peak_fault),
    .overload_fault_o (over_fault),
    .heat_level_o     (heat_level),
    .mag_o            (out_mag)
  );

  // Pack the result; zero fill up to whole bytes
  assign m_axis_tdata = OUT_DW'({out_mag, heat_level, over_fault, peak_fault});

endmodule

@@ src/dcp_checker.sv @@
// ----------------------------------------------------------------------------
// Drive current protection checker
// Port-level assertions on the protection unit, bound to the top level.
// ----------------------------------------------------------------------------
module dcp_checker #(
  parameter int unsigned OUT_DW = 88
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A new result follows an earlier input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input transfer");

  // The input side only back-pressures while a result is waiting
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind drive_current_protection_unit dcp_checker #(
  .OUT_DW (OUT_DW)
) u_dcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
